// ===== rtl/smm_pkg.sv =====
package smm_pkg;

  localparam int unsigned KIND_W  = 2;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned PROD_W  = 40;
  localparam int unsigned SIZE_W  = 4;
  localparam int unsigned CFG_W   = 2;

  localparam logic [KIND_W-1:0] KIND_LOAD_A = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_B = 2'd1;
  localparam logic [KIND_W-1:0] KIND_START  = 2'd2;

  localparam logic [CFG_W-1:0] REG_OUTER_SIZE = 2'd0;
  localparam logic [CFG_W-1:0] REG_INNER_SIZE = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } smm_state_t;

  typedef struct packed {
    logic a_we;
    logic b_we;
  } smm_wr_t;

endpackage

// ===== rtl/smm_if.sv =====
interface smm_in_if;
  import smm_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic [IDX_W-1:0]          row;
  logic [IDX_W-1:0]          col;
  logic signed [VALUE_W-1:0] value;
  modport source (output valid, kind, row, col, value, input ready);
  modport sink (input valid, kind, row, col, value, output ready);
endinterface

interface smm_out_if;
  import smm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic signed [PROD_W-1:0] product_value;
  logic                     last;
  modport source (output valid, out_row, out_col, product_value, last, input ready);
  modport sink (input valid, out_row, out_col, product_value, last, output ready);
endinterface

interface smm_cfg_if;
  import smm_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_W-1:0]  index;
  logic [SIZE_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/smm_store.sv =====
module smm_store
  import smm_pkg::*;
#(
  parameter int unsigned AW = 6
) (
  input  logic                      clk,
  input  smm_wr_t                   wr,
  input  logic [AW-1:0]             waddr,
  input  logic signed [VALUE_W-1:0] wdata,
  input  logic [AW-1:0]             a_raddr,
  input  logic [AW-1:0]             b_raddr,
  output logic signed [VALUE_W-1:0] a_rdata,
  output logic signed [VALUE_W-1:0] b_rdata
);

  logic signed [VALUE_W-1:0] mem_a [2**AW];
  logic signed [VALUE_W-1:0] mem_b [2**AW];

  always_ff @(posedge clk) begin
    if (wr.a_we) begin
      mem_a[waddr] <= wdata;
    end
    a_rdata <= mem_a[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (wr.b_we) begin
      mem_b[waddr] <= wdata;
    end
    b_rdata <= mem_b[b_raddr];
  end

endmodule

// ===== rtl/strassen_matrix_multiply_unit.sv =====
// Matrix multiplier for signed 16-bit elements with an exact 40-bit product.
// The in channel carries one item per element: kind load A or load B writes
// value at (row, col) into that matrix's store; a start item computes the
// outer_size by outer_size product and sends it on the out channel in
// row-major order, last marking its final element. Loads outside the stated
// sizes are kept but not used. The cfg channel writes outer_size (index 0)
// and inner_size (index 1); it is always ready. The user must write it only
// while idle; the block itself does not enforce this. For a start, each
// element is one multiply-accumulate per inner step on a single multiplier,
// fed by one read of each store per cycle, then a drain of the pipeline and a
// hand-over of the element. in.ready is low while a product is being
// computed. The result sits in an output register; when the receiver stalls,
// the sequencer waits at that element until it is taken. Synchronous reset
// sets both sizes to 8, empties the output register and returns to idle;
// store contents are undefined until written.
module strassen_matrix_multiply_unit
  import smm_pkg::*;
#(
  parameter int unsigned MAX_SIZE = 8
) (
  input logic        clk,
  input logic        rst_n,
  smm_in_if.sink     in,
  smm_out_if.source  out,
  smm_cfg_if.sink    cfg
);

  localparam int unsigned AW = $clog2(MAX_SIZE);
  localparam int unsigned CW = $clog2(MAX_SIZE + 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_SIZE);

  smm_state_t state_r, state_nxt;
  logic [SIZE_W-1:0] outer_r, inner_r;
  logic [CW-1:0] outer_eff, inner_eff;
  logic [CW-1:0] i_r, j_r, k_r;
  logic p1_v_r, p2_v_r;
  logic signed [31:0] prod_r;
  logic signed [PROD_W-1:0] acc_r;
  logic out_v_r;
  logic [IDX_W-1:0] orow_r, ocol_r;
  logic signed [PROD_W-1:0] oval_r;
  logic olast_r;

  logic iss, load_out, last_k, last_elem, out_free, start_ok;
  smm_wr_t wr;
  logic [2*AW-1:0] waddr, a_raddr, b_raddr;
  logic signed [VALUE_W-1:0] a_q, b_q;
  logic [CW+IDX_W:0] row_x, col_x;

  always_comb begin
    outer_eff = ({1'b0, outer_r} > 5'(MAX_SIZE)) ? MAXC : CW'({1'b0, outer_r});
    inner_eff = ({1'b0, inner_r} > 5'(MAX_SIZE)) ? MAXC : CW'({1'b0, inner_r});
  end

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outer_r <= SIZE_W'(8);
      inner_r <= SIZE_W'(8);
    end else if (cfg.valid) begin
      if (cfg.index == REG_OUTER_SIZE) begin
        outer_r <= cfg.data;
      end else if (cfg.index == REG_INNER_SIZE) begin
        inner_r <= cfg.data;
      end
    end
  end

  assign row_x = (CW + IDX_W + 1)'(in.row);
  assign col_x = (CW + IDX_W + 1)'(in.col);
  assign waddr = {row_x[AW-1:0], col_x[AW-1:0]};

  always_comb begin
    wr.a_we = 1'b0;
    wr.b_we = 1'b0;
    if (in.valid && in.ready && row_x < (CW + IDX_W + 1)'(MAX_SIZE)
        && col_x < (CW + IDX_W + 1)'(MAX_SIZE)) begin
      wr.a_we = (in.kind == KIND_LOAD_A);
      wr.b_we = (in.kind == KIND_LOAD_B);
    end
  end

  assign a_raddr = {i_r[AW-1:0], k_r[AW-1:0]};
  assign b_raddr = {k_r[AW-1:0], j_r[AW-1:0]};

  smm_store #(.AW(2 * AW)) u_store (
    .clk     (clk),
    .wr      (wr),
    .waddr   (waddr),
    .wdata   (in.value),
    .a_raddr (a_raddr),
    .b_raddr (b_raddr),
    .a_rdata (a_q),
    .b_rdata (b_q)
  );

  assign last_k    = (k_r + CW'(1)) >= inner_eff;
  assign last_elem = (i_r + CW'(1) == outer_eff) && (j_r + CW'(1) == outer_eff);
  assign out_free  = !out_v_r || out.ready;
  assign start_ok  = in.valid && (in.kind == KIND_START) && (outer_eff != '0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start_ok) begin
          state_nxt = (inner_eff == '0) ? ST_EMIT : ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_k) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!p1_v_r && !p2_v_r) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          if (last_elem) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = (inner_eff == '0) ? ST_EMIT : ST_RUN;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in.ready = 1'b0;
    iss      = 1'b0;
    load_out = 1'b0;
    case (state_r)
      ST_IDLE:  in.ready = 1'b1;
      ST_RUN:   iss      = 1'b1;
      ST_DRAIN: ;
      ST_EMIT:  load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      p1_v_r  <= 1'b0;
      p2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      p1_v_r  <= iss;
      p2_v_r  <= p1_v_r;
      if (load_out) begin
        out_v_r <= 1'b1;
      end else if (out.ready) begin
        out_v_r <= 1'b0;
      end
      if (state_r == ST_IDLE) begin
        i_r <= '0;
        j_r <= '0;
        k_r <= '0;
      end else if (iss) begin
        k_r <= k_r + CW'(1);
      end else if (load_out) begin
        k_r <= '0;
        if (j_r + CW'(1) == outer_eff) begin
          j_r <= '0;
          i_r <= i_r + CW'(1);
        end else begin
          j_r <= j_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= a_q * b_q;
    if (state_r == ST_IDLE || load_out) begin
      acc_r <= '0;
    end else if (p2_v_r) begin
      acc_r <= acc_r + {{(PROD_W - 32){prod_r[31]}}, prod_r};
    end
    if (load_out) begin
      orow_r  <= IDX_W'(i_r);
      ocol_r  <= IDX_W'(j_r);
      oval_r  <= acc_r;
      olast_r <= last_elem;
    end
  end

  assign out.valid         = out_v_r;
  assign out.out_row       = orow_r;
  assign out.out_col       = ocol_r;
  assign out.product_value = oval_r;
  assign out.last          = olast_r;

`ifndef NO_ASSERTIONS
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in.ready |-> (!p1_v_r && !p2_v_r))
    else $error("input taken while the multiply pipeline is busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out.valid && !out.ready) |=> (out.valid &&
      $stable({out.out_row, out.out_col, out.product_value, out.last})))
    else $error("result item changed while the receiver stalled");
  a_run_k: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (k_r < inner_eff))
    else $error("inner index ran past the shared dimension");
`endif

endmodule

// ===== test/tb.sv =====
module tb;
  import smm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SIDE = 8;
  localparam int unsigned STALL_LIMIT = 6000;

  typedef struct {
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [PROD_W-1:0] value;
    logic                     last;
  } product_elem_t;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  smm_in_if  in_ch();
  smm_out_if out_ch();
  smm_cfg_if cfg_ch();

  strassen_matrix_multiply_unit #(.MAX_SIZE(SIDE)) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in    (in_ch),
    .out   (out_ch),
    .cfg   (cfg_ch)
  );

  always #2 clk = ~clk;

  logic signed [VALUE_W-1:0] a_cells [SIDE][SIDE];
  logic signed [VALUE_W-1:0] b_cells [SIDE][SIDE];
  logic [SIZE_W-1:0] outer_reg = 4'd8;
  logic [SIZE_W-1:0] inner_reg = 4'd8;

  product_elem_t pending_products[$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;
  bit calm = 1'b0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_LOAD_A;
    in_ch.row = '0;
    in_ch.col = '0;
    in_ch.value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_OUTER_SIZE;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  task automatic predict_product();
    int unsigned o;
    int unsigned n;
    longint acc;
    product_elem_t e;
    o = (outer_reg > SIDE) ? SIDE : outer_reg;
    n = (inner_reg > SIDE) ? SIDE : inner_reg;
    for (int i = 0; i < o; i++) begin
      for (int j = 0; j < o; j++) begin
        acc = 0;
        for (int k = 0; k < n; k++) begin
          acc += longint'(a_cells[i][k]) * longint'(b_cells[k][j]);
        end
        e.row = i[IDX_W-1:0];
        e.col = j[IDX_W-1:0];
        e.value = acc[PROD_W-1:0];
        e.last = (i == o - 1) && (j == o - 1);
        pending_products.insert(pending_products.size(), e);
      end
    end
  endtask

  task automatic send_item(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] row,
                           logic [IDX_W-1:0] col, logic signed [VALUE_W-1:0] value);
    while (!calm && $urandom_range(99) < 13) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.row <= row;
    in_ch.col <= col;
    in_ch.value <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    case (kind)
      KIND_LOAD_A: a_cells[row][col] = value;
      KIND_LOAD_B: b_cells[row][col] = value;
      KIND_START:  predict_product();
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_products.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_W-1:0] index, logic [SIZE_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (index == REG_OUTER_SIZE) outer_reg = data;
    else if (index == REG_INNER_SIZE) inner_reg = data;
    @(posedge clk);
  endtask

  task automatic set_sizes(logic [SIZE_W-1:0] o, logic [SIZE_W-1:0] n);
    wait_idle();
    write_reg(REG_OUTER_SIZE, o);
    write_reg(REG_INNER_SIZE, n);
  endtask

  function automatic logic signed [VALUE_W-1:0] rand_value();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      default: return VALUE_W'($urandom_range(16'hffff));
    endcase
  endfunction

  task automatic test_corner_cases();
    set_sizes(4'd1, 4'd1);
    send_item(KIND_LOAD_A, 3'd0, 3'd0, 16'sh8000);
    send_item(KIND_LOAD_B, 3'd0, 3'd0, 16'sh8000);
    send_item(KIND_START, 3'd0, 3'd0, 16'sh0000);
    send_item(KIND_LOAD_A, 3'd0, 3'd0, 16'sh7fff);
    send_item(KIND_START, 3'd7, 3'd7, 16'shffff);
    send_item(KIND_LOAD_A, 3'd0, 3'd1, 16'sh0005);
    send_item(KIND_LOAD_B, 3'd1, 3'd0, 16'sh0007);
    send_item(KIND_UNUSED, 3'd7, 3'd7, 16'sh7fff);
    send_item(KIND_START, 3'd0, 3'd0, 16'sh0000);
    set_sizes(4'd1, 4'd0);
    send_item(KIND_START, 3'd0, 3'd0, 16'sh0000);
    set_sizes(4'd0, 4'd1);
    send_item(KIND_START, 3'd0, 3'd0, 16'sh0000);
  endtask

  task automatic test_full_fill();
    set_sizes(4'd8, 4'd8);
    for (int r = 0; r < SIDE; r++) begin
      for (int c = 0; c < SIDE; c++) begin
        send_item(KIND_LOAD_A, r[2:0], c[2:0], rand_value());
        send_item(KIND_LOAD_B, r[2:0], c[2:0], rand_value());
      end
    end
    send_item(KIND_START, 3'd0, 3'd0, 16'sh0000);
  endtask

  task automatic test_random_phase(logic [SIZE_W-1:0] o, logic [SIZE_W-1:0] n);
    int unsigned pick;
    set_sizes(o, n);
    for (int i = 0; i < 24; i++) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_item(KIND_START, IDX_W'($urandom), IDX_W'($urandom), VALUE_W'($urandom));
      end else if (pick < 13) begin
        send_item(KIND_UNUSED, IDX_W'($urandom), IDX_W'($urandom), VALUE_W'($urandom));
      end else begin
        send_item(KIND_W'($urandom_range(1)), IDX_W'($urandom), IDX_W'($urandom),
                  rand_value());
      end
    end
    send_item(KIND_START, IDX_W'($urandom), IDX_W'($urandom), VALUE_W'($urandom));
  endtask

  task automatic test_output_backpressure();
    set_sizes(4'd8, 4'd8);
    hold_request = 400;
    send_item(KIND_START, 3'd0, 3'd0, 16'sh0000);
    for (int i = 0; i < 10; i++) begin
      send_item(KIND_W'($urandom_range(1)), IDX_W'($urandom), IDX_W'($urandom),
                rand_value());
    end
    send_item(KIND_START, 3'd0, 3'd0, 16'sh0000);
  endtask

  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 13);
    end
  end

  always @(posedge clk) begin
    product_elem_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_products.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected item: row %0d col %0d value %0d",
                                       out_ch.out_row, out_ch.out_col, out_ch.product_value);
      end else begin
        e = pending_products.pop_front();
        if (out_ch.out_row !== e.row || out_ch.out_col !== e.col ||
            out_ch.product_value !== e.value || out_ch.last !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected (%0d,%0d) %0d last %0b, got (%0d,%0d) %0d last %0b",
                     e.row, e.col, e.value, e.last, out_ch.out_row, out_ch.out_col,
                     out_ch.product_value, out_ch.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_cases();
    calm = 1'b1;
    test_full_fill();
    calm = 1'b0;
    test_random_phase(4'd8, 4'd8);
    test_random_phase(4'd3, 4'd5);
    test_random_phase(4'd15, 4'd15);
    test_random_phase(4'd2, 4'd1);
    calm = 1'b1;
    test_random_phase(4'd5, 4'd8);
    calm = 1'b0;
    test_random_phase(4'd8, 4'd3);
    test_random_phase(4'd1, 4'd8);
    test_output_backpressure();
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_products.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/smm_pkg.sv
rtl/smm_if.sv
rtl/smm_store.sv
rtl/strassen_matrix_multiply_unit.sv
test/tb.sv
